// File: src/ecsp_pkg.sv
// Shared types and constants for the encoder capture speed/position block.
// Used by encoder_capture_speed_position; no dependencies.
package ecsp_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int TIMER_WIDTH  = 16;
   localparam int CHAN_W       = 3;
   localparam int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int TIME_W       = 16;
   localparam int FREQ_W       = 27;
   localparam int OVF_TICKS_W  = 17;
   localparam int WORD_W       = 32;
   localparam int CSR_IDX_W    = 4;
   localparam int STEP_W       = $clog2(FREQ_W);

   localparam logic [FREQ_W-1:0]      TICK_RATE_RESET = FREQ_W'(1663366);
   localparam logic [OVF_TICKS_W-1:0] OVF_TICKS_RESET = OVF_TICKS_W'(65532);

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_OVF_TICKS = CSR_IDX_W'(1);

   localparam logic [1:0] REQ_OVERFLOW = 2'd0;
   localparam logic [1:0] REQ_CAPTURE  = 2'd1;
   localparam logic [1:0] REQ_SAMPLE   = 2'd2;

   typedef struct packed {
      logic [TIMER_WIDTH-1:0] prev_time;
      logic [TIMER_WIDTH-1:0] curr_time;
      logic [WORD_W-1:0]      prev_ovf;
      logic [WORD_W-1:0]      curr_ovf;
      logic                   phase;
      logic [WORD_W-1:0]      pending;
      logic [WORD_W-1:0]      position;
   } chan_entry_type;

   localparam int ENTRY_W = $bits(chan_entry_type);

endpackage

// File: src/ecsp_ram.sv
// Generic dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
module ecsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/encoder_capture_speed_position.sv
// Encoder capture block top level: channel state RAM, sequencer, divider.
// Depends on ecsp_pkg and ecsp_ram.
//
// Usage:
//   Request channel (req_*): valid/stall. req_type selects timer overflow,
//   capture edge or channel sample; req_stall is high while an item is in work.
//   Response channel (rsp_*): valid/stall, one transaction per sample of a
//   channel in range. Overflow, capture and unused types give no response.
//   Config channel (csr_*): valid/ready, always ready; index 0 tick rate,
//   index 1 overflow ticks. Write only while the block is idle.
// Sequence:
//   Overflow and ignored items: handled in idle. Capture: read, write back.
//   Sample: read, multiply, sum, then a 27-step restoring divider producing
//   one quotient bit per cycle, up to the response register; the divider is
//   skipped when the period is zero. The next request is taken in the cycle
//   after the response register loads. The divider sets the sample rate.
// Reset: synchronous, clears the overflow counter, all channel entries
//   (per-entry valid bits, no clearing pass) and restores config defaults.
// Stall: the finished response waits in its output register; the sequencer
//   holds in its final state until the register frees, then accepts again.
module encoder_capture_speed_position (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [ecsp_pkg::CHAN_W-1:0]         req_chan_index,
   input  logic [ecsp_pkg::TIME_W-1:0]         req_capture_time,
   input  logic                                req_phase_b,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ecsp_pkg::CHAN_W-1:0]         rsp_out_channel,
   output logic [ecsp_pkg::FREQ_W-1:0]         rsp_frequency_hz,
   output logic                                rsp_direction,
   output logic signed [ecsp_pkg::WORD_W-1:0]  rsp_position,
   output logic                                rsp_zero_period,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ecsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ecsp_pkg::WORD_W-1:0]         csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_SUM,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                           state_ff;
   logic [ecsp_pkg::FREQ_W-1:0]         tick_rate_ff;
   logic [ecsp_pkg::OVF_TICKS_W-1:0]    ovf_ticks_ff;
   logic [ecsp_pkg::WORD_W-1:0]         ovf_count_ff;
   logic [ecsp_pkg::NUM_CHANNELS-1:0]   valid_ff;
   logic                                rd_valid_ff;

   logic [1:0]                          type_ff;
   logic [ecsp_pkg::ADDR_W-1:0]         addr_ff;
   logic [ecsp_pkg::CHAN_W-1:0]         chan_ff;
   logic [ecsp_pkg::TIMER_WIDTH-1:0]    time_ff;
   logic                                phase_b_ff;

   logic [ecsp_pkg::WORD_W-1:0]         dov_ff;
   logic [ecsp_pkg::WORD_W-1:0]         tdiff_ff;
   logic [ecsp_pkg::WORD_W-1:0]         prod_ff;
   logic [ecsp_pkg::WORD_W-1:0]         total_ff;
   logic [ecsp_pkg::WORD_W-1:0]         rem_ff;
   logic [ecsp_pkg::FREQ_W-1:0]         num_ff;
   logic [ecsp_pkg::STEP_W-1:0]         step_ff;
   logic                                zero_ff;
   logic                                dir_ff;
   logic [ecsp_pkg::WORD_W-1:0]         pos_ff;

   logic                                rsp_valid_ff;
   logic [ecsp_pkg::CHAN_W-1:0]         rsp_chan_ff;
   logic [ecsp_pkg::FREQ_W-1:0]         rsp_freq_ff;
   logic                                rsp_dir_ff;
   logic [ecsp_pkg::WORD_W-1:0]         rsp_pos_ff;
   logic                                rsp_zero_ff;

   logic                                req_accept;
   logic                                chan_in_range;
   logic [ecsp_pkg::ENTRY_W-1:0]        ram_rdata;
   ecsp_pkg::chan_entry_type            entry_rd;
   ecsp_pkg::chan_entry_type            entry_wr;
   logic                                ram_we;
   logic [ecsp_pkg::WORD_W-1:0]         pos_new;
   logic [ecsp_pkg::WORD_W-1:0]         sum_in;
   logic [ecsp_pkg::WORD_W:0]           trial;
   logic                                out_free;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign csr_ready     = 1'b1;
   assign chan_in_range = (32'(req_chan_index) < ecsp_pkg::NUM_CHANNELS);
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   assign entry_rd = rd_valid_ff ? ecsp_pkg::chan_entry_type'(ram_rdata)
                                 : ecsp_pkg::chan_entry_type'('0);

   assign pos_new = entry_rd.phase ? (entry_rd.position + entry_rd.pending)
                                   : (entry_rd.position - entry_rd.pending);

   always_comb begin
      entry_wr = entry_rd;
      if (type_ff == ecsp_pkg::REQ_CAPTURE) begin
         entry_wr.prev_time = entry_rd.curr_time;
         entry_wr.curr_time = time_ff;
         entry_wr.prev_ovf  = entry_rd.curr_ovf;
         entry_wr.curr_ovf  = ovf_count_ff;
         entry_wr.phase     = phase_b_ff;
         entry_wr.pending   = entry_rd.pending + ecsp_pkg::WORD_W'(1);
      end else begin
         entry_wr.pending  = '0;
         entry_wr.position = pos_new;
      end
   end

   assign ram_we = (state_ff == ST_READ);
   assign sum_in = prod_ff + tdiff_ff;
   assign trial  = {rem_ff, num_ff[ecsp_pkg::FREQ_W-1]} - {1'b0, total_ff};

   ecsp_ram #(
      .WIDTH (ecsp_pkg::ENTRY_W),
      .DEPTH (ecsp_pkg::NUM_CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (ecsp_pkg::ENTRY_W'(entry_wr)),
      .rd_addr (ecsp_pkg::ADDR_W'(req_chan_index)),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_rate_ff <= ecsp_pkg::TICK_RATE_RESET;
         ovf_ticks_ff <= ecsp_pkg::OVF_TICKS_RESET;
         ovf_count_ff <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == ecsp_pkg::CSR_TICK_RATE) begin
               tick_rate_ff <= csr_wdata[ecsp_pkg::FREQ_W-1:0];
            end else if (csr_index == ecsp_pkg::CSR_OVF_TICKS) begin
               ovf_ticks_ff <= csr_wdata[ecsp_pkg::OVF_TICKS_W-1:0];
            end
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  type_ff     <= req_type;
                  addr_ff     <= ecsp_pkg::ADDR_W'(req_chan_index);
                  chan_ff     <= req_chan_index;
                  time_ff     <= req_capture_time[ecsp_pkg::TIMER_WIDTH-1:0];
                  phase_b_ff  <= req_phase_b;
                  rd_valid_ff <= valid_ff[ecsp_pkg::ADDR_W'(req_chan_index)];
                  if (req_type == ecsp_pkg::REQ_OVERFLOW) begin
                     ovf_count_ff <= ovf_count_ff + ecsp_pkg::WORD_W'(1);
                  end else if ((req_type == ecsp_pkg::REQ_CAPTURE ||
                                req_type == ecsp_pkg::REQ_SAMPLE) && chan_in_range) begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               valid_ff[addr_ff] <= 1'b1;
               dov_ff   <= entry_rd.curr_ovf - entry_rd.prev_ovf;
               tdiff_ff <= ecsp_pkg::WORD_W'(entry_rd.curr_time)
                         - ecsp_pkg::WORD_W'(entry_rd.prev_time);
               dir_ff   <= entry_rd.phase;
               pos_ff   <= pos_new;
               state_ff <= (type_ff == ecsp_pkg::REQ_SAMPLE) ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
               prod_ff  <= dov_ff * ecsp_pkg::WORD_W'(ovf_ticks_ff);
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               total_ff <= sum_in;
               zero_ff  <= (sum_in == '0);
               rem_ff   <= '0;
               num_ff   <= (sum_in == '0) ? '0 : tick_rate_ff;
               step_ff  <= ecsp_pkg::STEP_W'(ecsp_pkg::FREQ_W - 1);
               state_ff <= (sum_in == '0) ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
               if (!trial[ecsp_pkg::WORD_W]) begin
                  rem_ff <= trial[ecsp_pkg::WORD_W-1:0];
               end else begin
                  rem_ff <= {rem_ff[ecsp_pkg::WORD_W-2:0], num_ff[ecsp_pkg::FREQ_W-1]};
               end
               num_ff  <= {num_ff[ecsp_pkg::FREQ_W-2:0], !trial[ecsp_pkg::WORD_W]};
               step_ff <= step_ff - ecsp_pkg::STEP_W'(1);
               if (step_ff == '0) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_chan_ff  <= chan_ff;
                  rsp_freq_ff  <= num_ff;
                  rsp_dir_ff   <= dir_ff;
                  rsp_pos_ff   <= pos_ff;
                  rsp_zero_ff  <= zero_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = rsp_chan_ff;
   assign rsp_frequency_hz = rsp_freq_ff;
   assign rsp_direction    = rsp_dir_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_zero_period  = rsp_zero_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> total_ff != '0)
      else $error("divider running on a zero period");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && out_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished sample not moved to the response register");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_zero_ff |-> rsp_freq_ff == '0)
      else $error("zero period response carries a frequency");

   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_type == ecsp_pkg::REQ_SAMPLE && chan_in_range |=> state_ff == ST_READ)
      else $error("sample transaction did not start a channel read");

endmodule
